// File: rtl/core/mtr_pkg.sv
// ----------------------------------------------------------------------------
// mtr_pkg
// Shared types and constants of the telemetry frame receiver.
// ----------------------------------------------------------------------------
package mtr_pkg;

  // frame header characters
  localparam logic [7:0] HdrDollar = 8'h24;
  localparam logic [7:0] HdrEm     = 8'h4d;
  localparam logic [7:0] HdrArrow  = 8'h3e;

  // payload bytes kept for decode, later ones only feed the checksum
  localparam int HeadBytes = 16;

  localparam logic [6:0] AltScale = 7'd100;

  // queue depths
  localparam int JobDepthDefault = 2;
  localparam int ResDepthDefault = 2;

  // configuration reset values
  localparam logic [7:0] CmdRawGpsReset   = 8'd106;
  localparam logic [7:0] CmdAltitudeReset = 8'd109;
  localparam logic [7:0] CmdAnalogReset   = 8'd110;

  // telemetry reset values
  localparam logic [31:0] LatReset  = 32'd12312313;
  localparam logic [31:0] LonReset  = 32'd2342342;
  localparam logic [7:0]  SatsReset = 8'd3;
  localparam logic [31:0] AltReset  = 32'd300;

  // configuration register indexes
  typedef enum logic [1:0] {
    RegCmdRawGps   = 2'd0,
    RegCmdAltitude = 2'd1,
    RegCmdAnalog   = 2'd2,
    RegBaroMode    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] cmd_raw_gps;
    logic [7:0] cmd_altitude;
    logic [7:0] cmd_analog;
    logic       baro_altitude_mode;
  } cfg_t;

  // a checked frame waiting for decode
  typedef struct packed {
    logic [7:0]                command;
    logic [HeadBytes-1:0][7:0] head;
  } job_t;

  typedef struct packed {
    logic [7:0]         frame_command;
    logic [7:0]         gps_fix_type;
    logic [7:0]         satellite_count;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [31:0] altitude_cm;
    logic [15:0]        ground_speed;
    logic [7:0]         battery_level;
    logic signed [15:0] power_sum;
    logic [7:0]         signal_strength;
  } res_t;

endpackage

// File: rtl/core/mtr_fifo.sv
// ----------------------------------------------------------------------------
// mtr_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module mtr_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] rdata,
  output logic             empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// File: rtl/core/mtr_front.sv
// ----------------------------------------------------------------------------
// mtr_front
// Byte parser: header hunt, size, command, payload capture and checksum.
// ----------------------------------------------------------------------------
module mtr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    rx_byte,
  output logic          full,
  input  logic          job_full,
  output logic          job_push,
  output mtr_pkg::job_t job
);

  import mtr_pkg::*;

  localparam int HeadIdxW = $clog2(HeadBytes);

  typedef enum logic [2:0] {
    S_HUNT,
    S_GOT_DOLLAR,
    S_GOT_EM,
    S_GOT_ARROW,
    S_GOT_SIZE,
    S_PAYLOAD
  } state_t;

  state_t                    state;
  logic [7:0]                length;
  logic [7:0]                command;
  logic [7:0]                xsum;
  logic [7:0]                pos;
  logic [HeadBytes-1:0][7:0] head;
  logic                      accept;
  logic [7:0]                xsum_next;
  logic                      at_end;

  assign full      = job_full;
  assign accept    = push && !full;
  assign xsum_next = xsum ^ rx_byte;
  assign at_end    = (pos == length);
  assign job_push  = accept && (state == S_PAYLOAD) && at_end && (xsum_next == 8'd0);
  assign job.command = command;
  assign job.head    = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_HUNT;
      length  <= '0;
      command <= '0;
      xsum    <= '0;
      pos     <= '0;
      head    <= '0;
    end else if (accept) begin
      case (state)
        S_HUNT: begin
          state <= (rx_byte == HdrDollar) ? S_GOT_DOLLAR : S_HUNT;
        end
        S_GOT_DOLLAR: begin
          state <= (rx_byte == HdrEm) ? S_GOT_EM : S_HUNT;
        end
        S_GOT_EM: begin
          state <= (rx_byte == HdrArrow) ? S_GOT_ARROW : S_HUNT;
        end
        S_GOT_ARROW: begin
          length <= rx_byte;
          xsum   <= rx_byte;
          state  <= S_GOT_SIZE;
        end
        S_GOT_SIZE: begin
          command <= rx_byte;
          xsum    <= xsum_next;
          pos     <= '0;
          state   <= S_PAYLOAD;
        end
        S_PAYLOAD: begin
          xsum <= xsum_next;
          if (at_end) begin
            state <= S_HUNT;
          end else begin
            // bytes beyond the kept range only feed the checksum
            if (pos < 8'(HeadBytes)) begin
              head[pos[HeadIdxW-1:0]] <= rx_byte;
            end
            pos <= pos + 8'd1;
          end
        end
        default: begin
          state <= S_HUNT;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/mtr_back.sv
// ----------------------------------------------------------------------------
// mtr_back
// Frame decoder: updates telemetry registers and emits the snapshot.
// ----------------------------------------------------------------------------
module mtr_back (
  input  logic          clk,
  input  logic          rst,
  input  mtr_pkg::cfg_t cfg,
  input  logic          job_valid,
  input  mtr_pkg::job_t job,
  output logic          job_pop,
  input  logic          res_full,
  output logic          res_push,
  output mtr_pkg::res_t res
);

  import mtr_pkg::*;

  localparam int HeadIdxW = $clog2(HeadBytes);
  // read positions of a shared-code decode run up to 19
  localparam int PosW     = 5;

  logic [31:0] lat;
  logic [31:0] lon;
  logic [7:0]  fix;
  logic [7:0]  sats;
  logic [31:0] alt;
  logic [15:0] speed;
  logic [7:0]  vbat;
  logic [15:0] psum;
  logic [7:0]  rssi;

  logic [31:0] lat_next;
  logic [31:0] lon_next;
  logic [7:0]  fix_next;
  logic [7:0]  sats_next;
  logic [31:0] alt_next;
  logic [15:0] speed_next;
  logic [7:0]  vbat_next;
  logic [15:0] psum_next;
  logic [7:0]  rssi_next;

  logic            is_gps;
  logic            is_alt;
  logic            is_analog;
  logic            alt_reads;
  logic [PosW-1:0] alt_base;
  logic [PosW-1:0] ana_base;
  logic [22:0]     alt_prod;
  logic            fire;

  // payload byte at a read position, zero past the kept bytes
  function automatic logic [7:0] head_at(logic [HeadBytes-1:0][7:0] h, logic [PosW-1:0] p);
    return (p < PosW'(HeadBytes)) ? h[p[HeadIdxW-1:0]] : 8'd0;
  endfunction

  assign fire      = job_valid && !res_full;
  assign job_pop   = fire;
  assign res_push  = fire;
  assign is_gps    = (job.command == cfg.cmd_raw_gps);
  assign is_alt    = (job.command == cfg.cmd_altitude);
  assign is_analog = (job.command == cfg.cmd_analog);
  assign alt_reads = is_alt && cfg.baro_altitude_mode;
  assign alt_prod  = {7'd0, job.head[11], job.head[10]} * {16'd0, AltScale};

  // shared codes decode in turn from one read position
  assign alt_base = !is_gps ? 5'd0 : (cfg.baro_altitude_mode ? 5'd12 : 5'd14);
  assign ana_base = alt_base + (alt_reads ? 5'd4 : 5'd0);

  always_comb begin
    lat_next   = lat;
    lon_next   = lon;
    fix_next   = fix;
    sats_next  = sats;
    alt_next   = alt;
    speed_next = speed;
    vbat_next  = vbat;
    psum_next  = psum;
    rssi_next  = rssi;
    if (is_gps) begin
      fix_next  = job.head[0];
      sats_next = job.head[1];
      lat_next  = {job.head[5], job.head[4], job.head[3], job.head[2]};
      lon_next  = {job.head[9], job.head[8], job.head[7], job.head[6]};
      if (cfg.baro_altitude_mode) begin
        speed_next = {job.head[11], job.head[10]};
      end else begin
        alt_next   = {9'd0, alt_prod};
        speed_next = {job.head[13], job.head[12]};
      end
    end
    if (alt_reads) begin
      alt_next = {head_at(job.head, alt_base + 5'd3), head_at(job.head, alt_base + 5'd2),
                  head_at(job.head, alt_base + 5'd1), head_at(job.head, alt_base)};
    end
    if (is_analog) begin
      vbat_next = head_at(job.head, ana_base);
      psum_next = {head_at(job.head, ana_base + 5'd2), head_at(job.head, ana_base + 5'd1)};
      rssi_next = head_at(job.head, ana_base + 5'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lat   <= LatReset;
      lon   <= LonReset;
      fix   <= '0;
      sats  <= SatsReset;
      alt   <= AltReset;
      speed <= '0;
      vbat  <= '0;
      psum  <= '0;
      rssi  <= '0;
    end else if (fire) begin
      lat   <= lat_next;
      lon   <= lon_next;
      fix   <= fix_next;
      sats  <= sats_next;
      alt   <= alt_next;
      speed <= speed_next;
      vbat  <= vbat_next;
      psum  <= psum_next;
      rssi  <= rssi_next;
    end
  end

  assign res.frame_command   = job.command;
  assign res.gps_fix_type    = fix_next;
  assign res.satellite_count = sats_next;
  assign res.latitude        = lat_next;
  assign res.longitude       = lon_next;
  assign res.altitude_cm     = alt_next;
  assign res.ground_speed    = speed_next;
  assign res.battery_level   = vbat_next;
  assign res.power_sum       = psum_next;
  assign res.signal_strength = rssi_next;

endmodule

// File: rtl/core/msp_telemetry_frame_receiver.sv
// ----------------------------------------------------------------------------
// msp_telemetry_frame_receiver
// Serial telemetry frame receiver: parses frames, decodes telemetry fields.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle, set by the parser taking a byte each cycle;
//   input stalls only while the job queue is full
// path: the frame taken with its checksum byte goes into the job queue, then is
//   decoded into the result queue, whose head drives the result ports
// reset: synchronous; parser hunts for a header, queues empty, telemetry and
//   command code registers return to their default values
module msp_telemetry_frame_receiver #(
  parameter int JobDepth = mtr_pkg::JobDepthDefault,
  parameter int ResDepth = mtr_pkg::ResDepthDefault
) (
  input  logic               clk,
  input  logic               rst,
  // byte input
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte,
  // result output
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         frame_command,
  output logic [7:0]         gps_fix_type,
  output logic [7:0]         satellite_count,
  output logic signed [31:0] latitude,
  output logic signed [31:0] longitude,
  output logic signed [31:0] altitude_cm,
  output logic [15:0]        ground_speed,
  output logic [7:0]         battery_level,
  output logic signed [15:0] power_sum,
  output logic [7:0]         signal_strength,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import mtr_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_write;

  job_t     job_in;
  job_t     job_out;
  logic     job_push;
  logic     job_full;
  logic     job_pop;
  logic     job_empty;

  res_t     res_in;
  res_t     res_out;
  logic     res_push;
  logic     res_full;

  // configuration port
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cmd_raw_gps        <= CmdRawGpsReset;
      cfg.cmd_altitude       <= CmdAltitudeReset;
      cfg.cmd_analog         <= CmdAnalogReset;
      cfg.baro_altitude_mode <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx)
        RegCmdRawGps:   cfg.cmd_raw_gps        <= pwdata[7:0];
        RegCmdAltitude: cfg.cmd_altitude       <= pwdata[7:0];
        RegCmdAnalog:   cfg.cmd_analog         <= pwdata[7:0];
        RegBaroMode:    cfg.baro_altitude_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegCmdRawGps:   prdata = {24'd0, cfg.cmd_raw_gps};
      RegCmdAltitude: prdata = {24'd0, cfg.cmd_altitude};
      RegCmdAnalog:   prdata = {24'd0, cfg.cmd_analog};
      RegBaroMode:    prdata = {31'd0, cfg.baro_altitude_mode};
      default:        prdata = '0;
    endcase
  end

  mtr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .rx_byte  (rx_byte),
    .full     (full),
    .job_full (job_full),
    .job_push (job_push),
    .job      (job_in)
  );

  mtr_fifo #(
    .Width ($bits(job_t)),
    .Depth (JobDepth)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  mtr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (!job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  mtr_fifo #(
    .Width ($bits(res_t)),
    .Depth (ResDepth)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign frame_command   = res_out.frame_command;
  assign gps_fix_type    = res_out.gps_fix_type;
  assign satellite_count = res_out.satellite_count;
  assign latitude        = res_out.latitude;
  assign longitude       = res_out.longitude;
  assign altitude_cm     = res_out.altitude_cm;
  assign ground_speed    = res_out.ground_speed;
  assign battery_level   = res_out.battery_level;
  assign power_sum       = res_out.power_sum;
  assign signal_strength = res_out.signal_strength;

endmodule

// File: rtl/core/mtr_checker.sv
// ----------------------------------------------------------------------------
// mtr_checker
// Port-level checks of the telemetry frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module mtr_checker (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [7:0]         frame_command,
  input logic signed [31:0] latitude,
  input logic               psel,
  input logic               pwrite,
  input logic [3:0]         paddr,
  input logic [31:0]        prdata,
  input logic               pready
);

  import mtr_pkg::*;

  // reset leaves both queues empty
  a_reset_state: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // the configuration port never inserts wait states
  a_no_wait: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

  // mode register reads back as a single bit
  a_mode_width: assert property (@(posedge clk) disable iff (rst)
    (psel && !pwrite && paddr[3:2] == RegBaroMode) |-> (prdata[31:1] == 31'd0))
    else $error("mode register has stray bits");

  // a waiting item holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(frame_command) && $stable(latitude)))
    else $error("waiting item changed");

endmodule

bind msp_telemetry_frame_receiver mtr_checker u_mtr_checker (.*);

// File: verif/msp_telemetry_frame_receiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msp_telemetry_frame_receiver_tb
// Feeds serial bytes (framed telemetry, broken headers, bad checksums, noise)
// through the receiver under several command-code and altitude-mode settings
// and gap patterns, and checks every snapshot against a byte-level parser.
// ----------------------------------------------------------------------------
module msp_telemetry_frame_receiver_tb;
  import mtr_pkg::*;

  localparam int HeadKeep    = 16;    // payload bytes the parser remembers
  localparam int QuietLimit  = 5000;  // cycles with no handshake before giving up
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 300;

  typedef enum logic [2:0] {
    ScanIdle, SawDollar, SawEm, SawArrow, SawSize, InPayload
  } scan_t;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               push    = 1'b0;
  logic [7:0]         rx_byte = 8'h00;
  logic               pop     = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [3:0]         paddr   = 4'h0;
  logic [31:0]        pwdata  = 32'h0;
  logic               full;
  logic               empty;
  logic [7:0]         frame_command;
  logic [7:0]         gps_fix_type;
  logic [7:0]         satellite_count;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  logic signed [31:0] altitude_cm;
  logic [15:0]        ground_speed;
  logic [7:0]         battery_level;
  logic signed [15:0] power_sum;
  logic [7:0]         signal_strength;
  logic [31:0]        prdata;
  logic               pready;

  msp_telemetry_frame_receiver dut (.*);

  always #1 clk = ~clk;

  // parser copy
  scan_t      scan_state = ScanIdle;
  logic [7:0] frame_len  = 8'h00;
  logic [7:0] frame_cmd  = 8'h00;
  logic [7:0] frame_xor  = 8'h00;
  logic [7:0] frame_pos  = 8'h00;
  logic [7:0] payload_head [HeadKeep] = '{default: 8'h00};
  int         read_pos   = 0;
  cfg_t       cfg = '{cmd_raw_gps: CmdRawGpsReset, cmd_altitude: CmdAltitudeReset,
                      cmd_analog: CmdAnalogReset, baro_altitude_mode: 1'b0};
  res_t       telem = '{frame_command: 8'h00, gps_fix_type: 8'h00,
                        satellite_count: SatsReset, latitude: LatReset,
                        longitude: LonReset, altitude_cm: AltReset,
                        ground_speed: 16'h0000, battery_level: 8'h00,
                        power_sum: 16'h0000, signal_strength: 8'h00};

  logic [7:0] rx_backlog [$];
  res_t       expected_snapshots [$];

  int bytes_queued   = 0;
  int bytes_taken    = 0;
  int snapshots_seen = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int send_gap_pct   = 0;
  int recv_gap_pct   = 0;
  bit hold_req       = 1'b0;
  bit hold_taken     = 1'b0;
  int hold_left      = 0;

  // little-endian read from the kept payload, zero past the kept bytes
  function automatic logic [31:0] take_le(int nbytes);
    logic [31:0] v;
    v = 32'h0;
    for (int k = 0; k < nbytes; k++) begin
      if (read_pos < HeadKeep) v[8*k +: 8] = payload_head[read_pos];
      read_pos++;
    end
    return v;
  endfunction

  function automatic void parse_rx_byte(logic [7:0] c);
    logic [31:0] word;
    case (scan_state)
      ScanIdle:  scan_state = (c == HdrDollar) ? SawDollar : ScanIdle;
      SawDollar: scan_state = (c == HdrEm) ? SawEm : ScanIdle;
      SawEm:     scan_state = (c == HdrArrow) ? SawArrow : ScanIdle;
      SawArrow: begin
        frame_len  = c;
        frame_xor  = c;
        scan_state = SawSize;
      end
      SawSize: begin
        frame_cmd  = c;
        frame_xor  = frame_xor ^ c;
        frame_pos  = 8'h00;
        scan_state = InPayload;
      end
      InPayload: begin
        frame_xor = frame_xor ^ c;
        if (frame_pos == frame_len) begin
          scan_state = ScanIdle;
          if (frame_xor == 8'h00) begin
            // shared codes decode in turn from one read position
            read_pos = 0;
            if (frame_cmd == cfg.cmd_raw_gps) begin
              word = take_le(1);
              telem.gps_fix_type = word[7:0];
              word = take_le(1);
              telem.satellite_count = word[7:0];
              telem.latitude  = take_le(4);
              telem.longitude = take_le(4);
              if (!cfg.baro_altitude_mode) telem.altitude_cm = take_le(2) * 32'd100;
              word = take_le(2);
              telem.ground_speed = word[15:0];
            end
            if (frame_cmd == cfg.cmd_altitude && cfg.baro_altitude_mode) begin
              telem.altitude_cm = take_le(4);
            end
            if (frame_cmd == cfg.cmd_analog) begin
              word = take_le(1);
              telem.battery_level = word[7:0];
              word = take_le(2);
              telem.power_sum = word[15:0];
              word = take_le(2);
              telem.signal_strength = word[7:0];
            end
            telem.frame_command = frame_cmd;
            expected_snapshots.push_back(telem);
          end
        end else begin
          if (frame_pos < HeadKeep) payload_head[frame_pos] = c;
          frame_pos = frame_pos + 8'd1;
        end
      end
      default: scan_state = ScanIdle;
    endcase
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        parse_rx_byte(rx_byte);
        bytes_taken++;
        void'(rx_backlog.pop_front());
      end
      // an item still waiting on full stays offered as is
      if (!(push && full)) begin
        if (rx_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          push    <= 1'b1;
          rx_byte <= rx_backlog[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string fname, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("snapshot %0d %s: expected %h, got %h", snapshots_seen, fname, want, got);
    end
  endtask

  // snapshot monitor
  always @(posedge clk) begin : snapshot_monitor
    res_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_snapshots.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("snapshot %0d arrived with none expected, command %h",
                     snapshots_seen, frame_command);
        end else begin
          want = expected_snapshots.pop_front();
          check_field("frame_command", frame_command, want.frame_command);
          check_field("gps_fix_type", gps_fix_type, want.gps_fix_type);
          check_field("satellite_count", satellite_count, want.satellite_count);
          check_field("latitude", latitude, want.latitude);
          check_field("longitude", longitude, want.longitude);
          check_field("altitude_cm", altitude_cm, want.altitude_cm);
          check_field("ground_speed", ground_speed, want.ground_speed);
          check_field("battery_level", battery_level, want.battery_level);
          check_field("power_sum", power_sum, want.power_sum);
          check_field("signal_strength", signal_strength, want.signal_strength);
        end
        snapshots_seen++;
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("no handshake for %0d cycles, %0d snapshots still expected",
                 QuietLimit, expected_snapshots.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic apb_write(reg_idx_t idx, logic [7:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegCmdRawGps:   cfg.cmd_raw_gps = val;
      RegCmdAltitude: cfg.cmd_altitude = val;
      RegCmdAnalog:   cfg.cmd_analog = val;
      RegBaroMode:    cfg.baro_altitude_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] gps, logic [7:0] alt, logic [7:0] ana, logic baro);
    apb_write(RegCmdRawGps, gps);
    apb_write(RegCmdAltitude, alt);
    apb_write(RegCmdAnalog, ana);
    apb_write(RegBaroMode, {7'h00, baro});
  endtask

  function automatic void offer(logic [7:0] b);
    rx_backlog.push_back(b);
    bytes_queued++;
  endfunction

  // fill < 0 gives random payload bytes
  function automatic void queue_frame(logic [7:0] cmd, int size, bit corrupt, int fill);
    logic [7:0] sum;
    logic [7:0] b;
    offer(HdrDollar);
    offer(HdrEm);
    offer(HdrArrow);
    offer(size[7:0]);
    offer(cmd);
    sum = size[7:0] ^ cmd;
    for (int k = 0; k < size; k++) begin
      b = (fill < 0) ? 8'($urandom) : fill[7:0];
      offer(b);
      sum = sum ^ b;
    end
    if (corrupt) sum = sum ^ (8'h01 << $urandom_range(0, 7));
    offer(sum);
  endfunction

  function automatic logic [7:0] pick_command();
    int r;
    logic [7:0] any_code;
    r = $urandom_range(0, 99);
    any_code = 8'($urandom);
    if (r < 30) return cfg.cmd_raw_gps;
    if (r < 50) return cfg.cmd_altitude;
    if (r < 75) return cfg.cmd_analog;
    return any_code;
  endfunction

  function automatic void queue_traffic(int nbytes);
    int target, r, sz, n;
    logic [7:0] b;
    logic [7:0] hdr [3] = '{HdrDollar, HdrEm, HdrArrow};
    target = bytes_queued + nbytes;
    while (bytes_queued < target) begin
      r = $urandom_range(0, 99);
      n = $urandom_range(0, 99);
      // mostly short payloads, a few long enough to overrun the kept bytes
      if (n < 70)      sz = $urandom_range(0, 16);
      else if (n < 98) sz = $urandom_range(17, 24);
      else             sz = $urandom_range(200, 255);
      if (r < 70) begin
        queue_frame(pick_command(), sz, 1'b0, -1);
      end else if (r < 80) begin
        queue_frame(pick_command(), sz, 1'b1, -1);
      end else if (r < 90) begin
        // header cut short by a wrong byte
        n = $urandom_range(0, 2);
        for (int k = 0; k < n; k++) offer(hdr[k]);
        b = 8'($urandom);
        if (b == hdr[n]) b = b ^ 8'h01;
        offer(b);
      end else begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) offer(8'($urandom));
      end
    end
  endfunction

  task automatic wait_drained();
    while (rx_backlog.size() != 0 || push || expected_snapshots.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  initial begin
    logic [7:0] code;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // a repeated dollar must not restart the header
    offer(HdrDollar);
    offer(HdrDollar);
    offer(HdrEm);
    offer(HdrArrow);
    // short analog payload: the tail of the decode reads old bytes
    queue_frame(cfg.cmd_analog, 3, 1'b0, 8'hff);
    queue_frame(8'hff, 0, 1'b0, -1);
    queue_frame(cfg.cmd_raw_gps, 0, 1'b1, -1);
    queue_traffic(170);
    wait_drained();

    // sender gaps, codes at both ends of the range, baro altitude
    set_config(8'h00, 8'hff, 8'($urandom_range(1, 254)), 1'b1);
    send_gap_pct = 72;
    queue_traffic(160);
    wait_drained();

    // receiver stalls, one code for all three decodes
    code = 8'($urandom);
    set_config(code, code, code, 1'b1);
    send_gap_pct = 0;
    recv_gap_pct = 72;
    queue_traffic(160);
    wait_drained();

    // light gaps both sides, raw gps and analog share a code
    code = 8'($urandom);
    set_config(code, code ^ 8'h5a, code, 1'b0);
    send_gap_pct = 9;
    recv_gap_pct = 9;
    queue_traffic(160);
    wait_drained();

    // long receiver hold while the sender keeps offering empty frames
    set_config(CmdRawGpsReset, CmdAltitudeReset, CmdAnalogReset, 1'b0);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_req = 1'b1;
    for (int k = 0; k < 24; k++) queue_frame(pick_command(), 0, 1'b0, -1);
    queue_traffic(80);
    wait_drained();

    $display("%0d bytes taken, %0d snapshots checked, %0d mismatches",
             bytes_taken, snapshots_seen, mismatch_count);
    $display("settings: default and extreme codes, shared codes, both altitude modes, gaps");
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
